[sv/integer_to_radix_digits_macros.svh]
// assertion macros shared by the integer to radix digits block
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`ifndef SYNTHESIS
`define ITRD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("itrd assertion failed");
`define ITRD_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("itrd forbidden condition seen");
`else
`define ITRD_ASSERT(label, clk, rst, prop)
`define ITRD_NEVER(label, clk, rst, expr)
`endif
`endif

[sv/itrd_pkg.sv]
// shared types, constants and helper functions of the integer to radix digits block
`timescale 1ns / 1ps
package itrd_pkg;
   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = 4;
   localparam int RADIX_W     = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int MAX_DIGITS  = 32;
   localparam int MAX_RADIX   = 16;
   localparam int COUNT_W     = $clog2(VALUE_W + MAX_DIGITS);
   localparam int REMAIN_W    = $clog2(MAX_DIGITS + 1);

   localparam logic [CHAR_W-1:0]  MINUS_CHAR  = 8'h2d;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_3 = 3'd4;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [3:0][3:0][CHAR_W-1:0] alphabet_type;

   localparam alphabet_type ALPHABET_RESET =
      {32'h66656463, 32'h62613938, 32'h37363534, 32'h33323130};

   // one bit of the number on its way up the cell row
   typedef struct packed {
      logic valid;
      logic carry;
   } token_type;

   typedef struct packed {
      logic                 clear;
      logic                 shift;
      logic [RADIX_W-1:0]   radix;
   } cell_ctrl_type;

   function automatic logic [RADIX_W-1:0] effective_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_W'(2)) begin
         res = RADIX_W'(2);
      end else if (r > RADIX_W'(MAX_RADIX)) begin
         res = RADIX_W'(MAX_RADIX);
      end else begin
         res = r;
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] char_of(input alphabet_type a, input digit_type d);
      return a[d[3:2]][d[1:0]];
   endfunction
endpackage

[sv/itrd_cell.sv]
// one radix digit cell: doubles its digit plus carry modulo the radix, or clears or shifts
`timescale 1ns / 1ps
module itrd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  itrd_pkg::cell_ctrl_type ctrl,
   input  itrd_pkg::digit_type    shift_in,
   input  itrd_pkg::token_type    token_in,
   output itrd_pkg::digit_type    digit,
   output itrd_pkg::token_type    token_out
);
   itrd_pkg::digit_type                 digit_ff, digit_in;
   itrd_pkg::token_type                 token_ff, token_in_next;
   logic [itrd_pkg::RADIX_W-1:0]        doubled;
   logic [itrd_pkg::RADIX_W-1:0]        reduced;
   logic                                over;

   always_comb begin
      doubled = {digit_ff, token_ff.carry};
      over    = doubled >= ctrl.radix;
      reduced = over ? doubled - ctrl.radix : doubled;
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift) begin
         digit_in = shift_in;
      end else if (token_ff.valid) begin
         digit_in = reduced[itrd_pkg::DIGIT_W-1:0];
      end else begin
         digit_in = digit_ff;
      end
      token_in_next = ctrl.clear ? '0 : token_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
      digit_ff <= digit_in;
   end

   assign digit     = digit_ff;
   assign token_out = '{valid: token_ff.valid, carry: over};
endmodule

[sv/integer_to_radix_digits.sv]
// Integer to radix text converter. Takes one signed 32-bit word and returns its text, one
// character per word, most significant digit first, a leading minus for negative values and
// last set on the final character. The magnitude enters a row of digit cells one bit per
// cycle, most significant bit first; each cell holds one radix digit and passes its carry to
// the next cell through its token register. An item is accepted, then run through the cell
// row, then given a minus sign if negative, then its digits are shifted out (leading zeros
// are dropped at one a cycle, others leave as the result side takes them).
`timescale 1ns / 1ps
`include "integer_to_radix_digits_macros.svh"
module integer_to_radix_digits (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [itrd_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [itrd_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                  rsp_last,
   input  logic                                  csr_write_enable,
   input  logic [itrd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [itrd_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   typedef enum logic [1:0] {IDLE, CONVERT, SIGN, DIGITS} state_type;

   state_type                          state_ff, state_in;
   logic [itrd_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [itrd_pkg::VALUE_W-1:0]       mag_ff, mag_in;
   logic [itrd_pkg::VALUE_W-1:0]       value_u;
   logic                               neg_ff, neg_in;
   logic                               seen_ff, seen_in;
   logic [itrd_pkg::REMAIN_W-1:0]      remain_ff, remain_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [itrd_pkg::CHAR_W-1:0]        rsp_character_ff, rsp_character_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic [itrd_pkg::RADIX_W-1:0]       radix_ff, radix_in;
   itrd_pkg::alphabet_type             alphabet_ff, alphabet_in;
   logic                               out_free;
   logic                               is_last;
   itrd_pkg::digit_type                top_digit;
   itrd_pkg::cell_ctrl_type            cell_ctrl;
   itrd_pkg::token_type                tok [itrd_pkg::MAX_DIGITS+1];
   itrd_pkg::digit_type                digits [itrd_pkg::MAX_DIGITS];

   assign tok[0] = '{valid: state_ff == CONVERT
                           && count_ff < itrd_pkg::COUNT_W'(itrd_pkg::VALUE_W),
                     carry: mag_ff[itrd_pkg::VALUE_W-1]};

   for (genvar i = 0; i < itrd_pkg::MAX_DIGITS; i++) begin : g_cell
      itrd_pkg::digit_type shift_src;
      if (i == 0) begin : g_first
         assign shift_src = '0;
      end else begin : g_rest
         assign shift_src = digits[i-1];
      end
      itrd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .shift_in  (shift_src),
         .token_in  (tok[i]),
         .digit     (digits[i]),
         .token_out (tok[i+1])
      );
   end

   assign value_u   = req_value;
   assign top_digit = digits[itrd_pkg::MAX_DIGITS-1];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = remain_ff == itrd_pkg::REMAIN_W'(1);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      mag_in           = mag_ff;
      neg_in           = neg_ff;
      seen_in          = seen_ff;
      remain_in        = remain_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      radix_in         = radix_ff;
      alphabet_in      = alphabet_ff;
      cell_ctrl        = '{clear: 1'b0, shift: 1'b0,
                           radix: itrd_pkg::effective_radix(radix_ff)};

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               neg_in          = value_u[itrd_pkg::VALUE_W-1];
               mag_in          = neg_in ? '0 - value_u : value_u;
               count_in        = '0;
               seen_in         = 1'b0;
               remain_in       = itrd_pkg::REMAIN_W'(itrd_pkg::MAX_DIGITS);
               cell_ctrl.clear = 1'b1;
               state_in        = CONVERT;
            end
         end
         CONVERT: begin
            mag_in   = mag_ff << 1;
            count_in = count_ff + 1'b1;
            if (count_ff == itrd_pkg::COUNT_W'(itrd_pkg::VALUE_W + itrd_pkg::MAX_DIGITS - 1)) begin
               state_in = neg_ff ? SIGN : DIGITS;
            end
         end
         SIGN: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_character_in = itrd_pkg::MINUS_CHAR;
               rsp_last_in      = 1'b0;
               state_in         = DIGITS;
            end
         end
         DIGITS: begin
            // leading zero cells are dropped without a word
            if (!seen_ff && top_digit == '0 && !is_last) begin
               cell_ctrl.shift = 1'b1;
               remain_in       = remain_ff - 1'b1;
            end else if (out_free) begin
               cell_ctrl.shift  = 1'b1;
               remain_in        = remain_ff - 1'b1;
               seen_in          = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_character_in = itrd_pkg::char_of(alphabet_ff, top_digit);
               rsp_last_in      = is_last;
               if (is_last) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            itrd_pkg::CSR_RADIX:   radix_in = csr_write_data[itrd_pkg::RADIX_W-1:0];
            itrd_pkg::CSR_ALPHA_0: alphabet_in[0] = csr_write_data;
            itrd_pkg::CSR_ALPHA_1: alphabet_in[1] = csr_write_data;
            itrd_pkg::CSR_ALPHA_2: alphabet_in[2] = csr_write_data;
            itrd_pkg::CSR_ALPHA_3: alphabet_in[3] = csr_write_data;
            default: begin
               radix_in = radix_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= itrd_pkg::RADIX_RESET;
         alphabet_ff  <= itrd_pkg::ALPHABET_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         seen_ff      <= seen_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
         radix_ff     <= radix_in;
         alphabet_ff  <= alphabet_in;
      end
      mag_ff           <= mag_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_ready     = state_ff == IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   // the top cell only passes bits while the row is converting
   `ITRD_ASSERT(a_top_token_in_convert, clock, reset, tok[itrd_pkg::MAX_DIGITS].valid |-> state_ff == CONVERT)
   // the final digit always goes out flagged last and ends the item
   `ITRD_ASSERT(a_last_digit_flagged, clock, reset, (state_ff == DIGITS && is_last && out_free) |=> (rsp_valid_ff && rsp_last_ff && state_ff == IDLE))
   `ITRD_NEVER(a_no_empty_digit_phase, clock, reset, state_ff == DIGITS && remain_ff == '0)
   // a waiting word is never overwritten
   `ITRD_ASSERT(a_word_holds, clock, reset, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_character_ff) && $stable(rsp_last_ff)))
endmodule
